FILE: hw/rtl/dlac_pkg.sv
// shared types, codes and reset values for the door lock alarm controller
package dlac_pkg;

    localparam int TIMER_BITS_DEF = 24;
    localparam int CFG_W          = 24;
    localparam int PRE_W          = 16;
    localparam int CFG_IDX_W      = 3;

    // register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_RELOCK_GRACE  = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_UNLOCK_BUTTON = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_UNLOCK_FRONT  = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_UNLOCK_CHAT   = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_UNLOCK_WEB    = 3'd4;
    localparam logic [CFG_IDX_W-1:0] CFG_UNLOCK_DEF    = 3'd5;
    localparam logic [CFG_IDX_W-1:0] CFG_PREALARM_WIN  = 3'd6;

    localparam logic [CFG_W-1:0] RELOCK_GRACE_RST = 24'd5000;
    localparam logic [CFG_W-1:0] UNLOCK_TIME_RST  = 24'd10000;
    localparam logic [PRE_W-1:0] PREALARM_WIN_RST = 16'd730;

    // request functions
    localparam logic [2:0] FUNC_TICK      = 3'd0;
    localparam logic [2:0] FUNC_UNLOCK    = 3'd1;
    localparam logic [2:0] FUNC_ENGAGE    = 3'd2;
    localparam logic [2:0] FUNC_DISENGAGE = 3'd3;
    localparam logic [2:0] FUNC_ABORT     = 3'd4;

    // request sources
    localparam logic [2:0] SRC_NONE   = 3'd0;
    localparam logic [2:0] SRC_BUTTON = 3'd1;
    localparam logic [2:0] SRC_FRONT  = 3'd2;
    localparam logic [2:0] SRC_CHAT   = 3'd3;
    localparam logic [2:0] SRC_WEB    = 3'd4;

    // result codes
    localparam logic [2:0] RC_SUCCESS        = 3'd0;
    localparam logic [2:0] RC_ALREADY_UNLOCK = 3'd1;
    localparam logic [2:0] RC_ALREADY_ENGAGE = 3'd2;
    localparam logic [2:0] RC_ALREADY_DISENG = 3'd3;
    localparam logic [2:0] RC_NOT_ACTIVE     = 3'd4;
    localparam logic [2:0] RC_TICK           = 3'd5;

    // door modes
    localparam logic [1:0] MODE_LOCKED     = 2'd0;
    localparam logic [1:0] MODE_WAIT_OPEN  = 2'd1;
    localparam logic [1:0] MODE_UNLOCKED   = 2'd2;
    localparam logic [1:0] MODE_DISENGAGED = 2'd3;

    // led modes
    localparam logic [1:0] LED_LOCKED     = 2'd0;
    localparam logic [1:0] LED_UNLOCKED   = 2'd1;
    localparam logic [1:0] LED_DISENGAGED = 2'd2;
    localparam logic [1:0] LED_ALARM      = 2'd3;

    // alarm phases
    localparam logic [1:0] PHASE_NONE     = 2'd0;
    localparam logic [1:0] PHASE_PREALARM = 2'd1;
    localparam logic [1:0] PHASE_ALARM    = 2'd2;

    // melodies
    localparam logic [2:0] MEL_NONE      = 3'd0;
    localparam logic [2:0] MEL_UNLOCK    = 3'd1;
    localparam logic [2:0] MEL_LOCK      = 3'd2;
    localparam logic [2:0] MEL_ENGAGE    = 3'd3;
    localparam logic [2:0] MEL_DISENGAGE = 3'd4;
    localparam logic [2:0] MEL_ABORTED   = 3'd5;

    typedef struct packed {
        logic [CFG_W-1:0] relock_grace_ms;
        logic [CFG_W-1:0] unlock_time_button;
        logic [CFG_W-1:0] unlock_time_front;
        logic [CFG_W-1:0] unlock_time_chat;
        logic [CFG_W-1:0] unlock_time_web;
        logic [CFG_W-1:0] unlock_time_default;
        logic [PRE_W-1:0] prealarm_window_ms;
    } t_cfg;

    typedef struct packed {
        logic [2:0] func;
        logic [2:0] request_source;
        logic       door_closed;
    } t_item;

    typedef struct packed {
        logic [2:0] result_code;
        logic [1:0] door_mode_out;
        logic       solenoid_on;
        logic [1:0] led_mode;
        logic       alarm_sound;
        logic       alarm_active;
        logic [2:0] melody_start;
    } t_result;

endpackage

FILE: hw/rtl/dlac_if.sv
// request and response channel interfaces
interface dlac_req_if;
    import dlac_pkg::*;
    logic       valid;
    logic       ready;
    logic [2:0] func;
    logic [2:0] request_source;
    logic       door_closed;

    modport source (output valid, func, request_source, door_closed, input ready);
    modport sink   (input valid, func, request_source, door_closed, output ready);
endinterface

interface dlac_rsp_if;
    import dlac_pkg::*;
    logic       valid;
    logic       ready;
    logic [2:0] result_code;
    logic [1:0] door_mode_out;
    logic       solenoid_on;
    logic [1:0] led_mode;
    logic       alarm_sound;
    logic       alarm_active;
    logic [2:0] melody_start;

    modport source (output valid, result_code, door_mode_out, solenoid_on, led_mode,
                    alarm_sound, alarm_active, melody_start, input ready);
    modport sink   (input valid, result_code, door_mode_out, solenoid_on, led_mode,
                    alarm_sound, alarm_active, melody_start, output ready);
endinterface

FILE: hw/rtl/door_lock_alarm_controller.sv
// door lock alarm controller top level: input stage, core and output handshake
// an accepted beat passes the input stage register, then the core result register
// throughput: one beat per cycle while the response is taken, set by the state update in the core
// while a finished result waits, the input stage takes one more beat, then drops ready
// reset (synchronous, active low) empties both stages, locks the door, clears
// the alarm and timers and loads the default register values
module door_lock_alarm_controller #(
    parameter int TIMER_BITS = dlac_pkg::TIMER_BITS_DEF
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    dlac_req_if.sink                       i_req,
    dlac_rsp_if.source                     o_rsp,
    input  logic                           i_cfg_we,
    input  logic [dlac_pkg::CFG_IDX_W-1:0] i_cfg_index,
    input  logic [dlac_pkg::CFG_W-1:0]     i_cfg_data
);
    import dlac_pkg::*;

    t_cfg    cfg;
    t_result res;
    t_item   r_s1_item;
    logic    r_s1_valid, n_s1_valid;
    logic    r_out_valid, n_out_valid;
    logic    adv;
    logic    fire;
    logic    in_take;

    assign adv     = !r_out_valid || o_rsp.ready;
    assign fire    = r_s1_valid && adv;
    assign in_take = i_req.valid && i_req.ready;

    assign i_req.ready = !r_s1_valid || adv;

    always_comb begin
        n_s1_valid = r_s1_valid;
        if (in_take) begin
            n_s1_valid = 1'b1;
        end else if (fire) begin
            n_s1_valid = 1'b0;
        end
        n_out_valid = r_out_valid;
        if (fire) begin
            n_out_valid = 1'b1;
        end else if (o_rsp.ready) begin
            n_out_valid = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid  <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_s1_valid  <= n_s1_valid;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_take) begin
            r_s1_item.func           <= i_req.func;
            r_s1_item.request_source <= i_req.request_source;
            r_s1_item.door_closed    <= i_req.door_closed;
        end
    end

    dlac_cfg_regs u_cfg (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .o_cfg       (cfg)
    );

    dlac_core #(
        .TIMER_BITS (TIMER_BITS)
    ) u_core (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_fire  (fire),
        .i_item  (r_s1_item),
        .i_cfg   (cfg),
        .o_res   (res)
    );

    assign o_rsp.valid         = r_out_valid;
    assign o_rsp.result_code   = res.result_code;
    assign o_rsp.door_mode_out = res.door_mode_out;
    assign o_rsp.solenoid_on   = res.solenoid_on;
    assign o_rsp.led_mode      = res.led_mode;
    assign o_rsp.alarm_sound   = res.alarm_sound;
    assign o_rsp.alarm_active  = res.alarm_active;
    assign o_rsp.melody_start  = res.melody_start;

endmodule

FILE: hw/rtl/dlac_cfg_regs.sv
// configuration register file
module dlac_cfg_regs (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_cfg_we,
    input  logic [dlac_pkg::CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [dlac_pkg::CFG_W-1:0]      i_cfg_data,
    output dlac_pkg::t_cfg                  o_cfg
);
    import dlac_pkg::*;

    t_cfg r_cfg;
    t_cfg n_cfg;

    always_comb begin
        n_cfg = r_cfg;
        if (i_cfg_we) begin
            case (i_cfg_index)
                CFG_RELOCK_GRACE:  n_cfg.relock_grace_ms     = i_cfg_data;
                CFG_UNLOCK_BUTTON: n_cfg.unlock_time_button  = i_cfg_data;
                CFG_UNLOCK_FRONT:  n_cfg.unlock_time_front   = i_cfg_data;
                CFG_UNLOCK_CHAT:   n_cfg.unlock_time_chat    = i_cfg_data;
                CFG_UNLOCK_WEB:    n_cfg.unlock_time_web     = i_cfg_data;
                CFG_UNLOCK_DEF:    n_cfg.unlock_time_default = i_cfg_data;
                CFG_PREALARM_WIN:  n_cfg.prealarm_window_ms  = i_cfg_data[PRE_W-1:0];
                default: ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.relock_grace_ms     <= RELOCK_GRACE_RST;
            r_cfg.unlock_time_button  <= UNLOCK_TIME_RST;
            r_cfg.unlock_time_front   <= UNLOCK_TIME_RST;
            r_cfg.unlock_time_chat    <= UNLOCK_TIME_RST;
            r_cfg.unlock_time_web     <= UNLOCK_TIME_RST;
            r_cfg.unlock_time_default <= UNLOCK_TIME_RST;
            r_cfg.prealarm_window_ms  <= PREALARM_WIN_RST;
        end else begin
            r_cfg <= n_cfg;
        end
    end

    assign o_cfg = r_cfg;

endmodule

FILE: hw/rtl/dlac_core.sv
// lock state, timers and result register, one beat per cycle while i_fire is high
module dlac_core #(
    parameter int TIMER_BITS = dlac_pkg::TIMER_BITS_DEF
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_fire,
    input  dlac_pkg::t_item   i_item,
    input  dlac_pkg::t_cfg    i_cfg,
    output dlac_pkg::t_result o_res
);
    import dlac_pkg::*;

    localparam int CMP_W = (TIMER_BITS > CFG_W) ? TIMER_BITS : CFG_W;
    localparam logic [TIMER_BITS-1:0] TMAX = '1;

    logic [1:0]            r_mode,  n_mode;
    logic [1:0]            r_phase, n_phase;
    logic [TIMER_BITS-1:0] r_since, n_since;
    logic [TIMER_BITS-1:0] r_ulf,   n_ulf;
    logic [PRE_W-1:0]      r_pre,   n_pre;
    logic                  r_latch, n_latch;
    logic [1:0]            r_lamp,  n_lamp;
    t_result               r_res,   n_res;

    logic [TIMER_BITS-1:0] since_inc;
    logic [TIMER_BITS-1:0] ulf_b;
    logic [TIMER_BITS-1:0] wait_src;
    logic [TIMER_BITS-1:0] wait_def;
    logic                  grace_hit;
    logic                  idle;
    logic                  dec;
    logic [2:0]            rc;
    logic [2:0]            mel;

    function automatic logic [TIMER_BITS-1:0] sat_wait(input logic [CFG_W-1:0] t);
        logic [CMP_W-1:0] te;
        te = CMP_W'(t);
        if (te > CMP_W'(TMAX)) begin
            te = CMP_W'(TMAX);
        end
        return TIMER_BITS'(te);
    endfunction

    function automatic logic [CFG_W-1:0] pick_wait(input logic [2:0] src, input t_cfg c);
        logic [CFG_W-1:0] w;
        case (src)
            SRC_BUTTON: w = c.unlock_time_button;
            SRC_FRONT:  w = c.unlock_time_front;
            SRC_CHAT:   w = c.unlock_time_chat;
            SRC_WEB:    w = c.unlock_time_web;
            default:    w = c.unlock_time_default;
        endcase
        return w;
    endfunction

    assign since_inc = (r_since == TMAX) ? r_since : r_since + TIMER_BITS'(1);
    assign grace_hit = CMP_W'(since_inc) >= CMP_W'(i_cfg.relock_grace_ms);
    assign wait_src  = sat_wait(pick_wait(i_item.request_source, i_cfg));
    assign wait_def  = sat_wait(i_cfg.unlock_time_default);
    assign idle      = (r_phase == PHASE_NONE);

    always_comb begin
        n_mode  = r_mode;
        n_phase = r_phase;
        n_since = r_since;
        n_ulf   = r_ulf;
        n_pre   = r_pre;
        n_latch = r_latch;
        n_lamp  = r_lamp;
        ulf_b   = r_ulf;
        dec     = 1'b0;
        rc      = RC_TICK;
        mel     = MEL_NONE;

        case (i_item.func)
            FUNC_TICK: begin
                n_since = since_inc;
                dec     = 1'b1;
                if (r_phase == PHASE_PREALARM) begin
                    if (i_item.door_closed) begin
                        n_phase = PHASE_NONE;
                    end else if (r_pre == '0) begin
                        n_phase = PHASE_ALARM;
                        n_lamp  = LED_ALARM;
                    end else begin
                        n_pre = r_pre - PRE_W'(1);
                    end
                end else if (r_phase == PHASE_NONE) begin
                    if (r_mode == MODE_LOCKED && !i_item.door_closed && grace_hit) begin
                        n_phase = PHASE_PREALARM;
                        n_pre   = i_cfg.prealarm_window_ms;
                        dec     = 1'b0;
                    end else begin
                        case (r_mode)
                            MODE_LOCKED: begin
                                // opened inside grace: unlock, then straight to unlocked
                                if (!i_item.door_closed) begin
                                    n_mode  = MODE_UNLOCKED;
                                    n_lamp  = LED_UNLOCKED;
                                    n_latch = 1'b1;
                                    ulf_b   = wait_def;
                                    mel     = MEL_UNLOCK;
                                end
                            end
                            MODE_UNLOCKED: begin
                                if (i_item.door_closed) begin
                                    n_mode  = MODE_LOCKED;
                                    n_lamp  = LED_LOCKED;
                                    n_latch = 1'b0;
                                    n_since = '0;
                                    mel     = MEL_LOCK;
                                end
                            end
                            MODE_WAIT_OPEN: begin
                                if (!i_item.door_closed) begin
                                    n_mode = MODE_UNLOCKED;
                                end else if (r_ulf == '0) begin
                                    n_mode  = MODE_LOCKED;
                                    n_lamp  = LED_LOCKED;
                                    n_latch = 1'b0;
                                    n_since = '0;
                                    mel     = MEL_LOCK;
                                end
                            end
                            default: ;
                        endcase
                    end
                end
                n_ulf = (dec && ulf_b != '0) ? ulf_b - TIMER_BITS'(1) : ulf_b;
            end
            FUNC_UNLOCK: begin
                rc = (r_mode != MODE_LOCKED) ? RC_ALREADY_UNLOCK : RC_SUCCESS;
                if (rc == RC_SUCCESS && idle) begin
                    n_mode  = MODE_WAIT_OPEN;
                    n_lamp  = LED_UNLOCKED;
                    n_latch = 1'b1;
                    n_ulf   = wait_src;
                    mel     = MEL_UNLOCK;
                end
            end
            FUNC_ENGAGE: begin
                rc = (r_mode != MODE_DISENGAGED) ? RC_ALREADY_ENGAGE : RC_SUCCESS;
                if (rc == RC_SUCCESS && idle) begin
                    if (i_item.door_closed) begin
                        n_mode  = MODE_LOCKED;
                        n_lamp  = LED_LOCKED;
                        n_latch = 1'b0;
                        n_since = '0;
                    end else begin
                        n_mode = MODE_UNLOCKED;
                        n_lamp = LED_UNLOCKED;
                    end
                    mel = MEL_ENGAGE;
                end
            end
            FUNC_DISENGAGE: begin
                rc = (r_mode == MODE_DISENGAGED) ? RC_ALREADY_DISENG : RC_SUCCESS;
                if (rc == RC_SUCCESS && idle) begin
                    n_mode  = MODE_DISENGAGED;
                    n_lamp  = LED_DISENGAGED;
                    n_latch = 1'b1;
                    mel     = MEL_DISENGAGE;
                end
            end
            FUNC_ABORT: begin
                rc = (r_phase == PHASE_ALARM) ? RC_SUCCESS : RC_NOT_ACTIVE;
                if (rc == RC_SUCCESS) begin
                    n_phase = PHASE_NONE;
                    if (i_item.door_closed) begin
                        if (r_mode != MODE_LOCKED) begin
                            n_mode  = MODE_LOCKED;
                            n_latch = 1'b0;
                            n_since = '0;
                        end
                        n_lamp = LED_LOCKED;
                    end else if (r_mode == MODE_LOCKED) begin
                        n_mode  = MODE_WAIT_OPEN;
                        n_lamp  = LED_UNLOCKED;
                        n_latch = 1'b1;
                        n_ulf   = wait_def;
                    end
                    mel = MEL_ABORTED;
                end
            end
            default: ;
        endcase

        n_res.result_code   = rc;
        n_res.door_mode_out = n_mode;
        n_res.solenoid_on   = n_latch;
        n_res.led_mode      = n_lamp;
        n_res.alarm_sound   = (n_phase != PHASE_NONE);
        n_res.alarm_active  = (n_phase == PHASE_ALARM);
        n_res.melody_start  = mel;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode  <= MODE_LOCKED;
            r_phase <= PHASE_NONE;
            r_since <= '0;
            r_ulf   <= '0;
            r_pre   <= '0;
            r_latch <= 1'b0;
            r_lamp  <= LED_LOCKED;
        end else if (i_fire) begin
            r_mode  <= n_mode;
            r_phase <= n_phase;
            r_since <= n_since;
            r_ulf   <= n_ulf;
            r_pre   <= n_pre;
            r_latch <= n_latch;
            r_lamp  <= n_lamp;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_fire) begin
            r_res <= n_res;
        end
    end

    assign o_res = r_res;

endmodule

FILE: hw/rtl/dlac_checker.sv
// port-level checks for the door lock alarm controller, bound to the top level
module dlac_checker (
    input logic       i_clk,
    input logic       i_rst_n,
    input logic       i_valid,
    input logic       i_ready,
    input logic [2:0] i_result_code,
    input logic [1:0] i_led_mode,
    input logic       i_alarm_sound,
    input logic       i_alarm_active,
    input logic [2:0] i_melody_start
);
    import dlac_pkg::*;

    // no result beat right after reset
    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !i_valid)
        else $error("result valid after reset");

    // full alarm always sounds
    a_alarm_sound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_valid && i_alarm_active |-> i_alarm_sound)
        else $error("alarm active without siren");

    // led shows alarm exactly in the full alarm phase
    a_led_alarm: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_valid |-> ((i_led_mode == LED_ALARM) == i_alarm_active))
        else $error("led alarm mismatch");

    // a melody only starts on success or on a tick
    a_melody_code: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_valid && (i_melody_start != MEL_NONE)
            |-> (i_result_code == RC_SUCCESS || i_result_code == RC_TICK))
        else $error("melody with failed request");

    // a stalled result beat holds
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_valid && !i_ready |=> i_valid && $stable(i_result_code)
            && $stable(i_melody_start) && $stable(i_led_mode))
        else $error("stalled result changed");

endmodule

bind door_lock_alarm_controller dlac_checker u_dlac_checker (
    .i_clk          (i_clk),
    .i_rst_n        (i_rst_n),
    .i_valid        (o_rsp.valid),
    .i_ready        (o_rsp.ready),
    .i_result_code  (o_rsp.result_code),
    .i_led_mode     (o_rsp.led_mode),
    .i_alarm_sound  (o_rsp.alarm_sound),
    .i_alarm_active (o_rsp.alarm_active),
    .i_melody_start (o_rsp.melody_start)
);
